// File: src/gpts_pkg.sv
// Package for the graph path and tree solver: item types, codes, sizes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package gpts_pkg;
    localparam int MaxVertices = 256;
    localparam int MaxEdges    = 1024;
    localparam int VtxW  = $clog2(MaxVertices);
    localparam int EdgeW = $clog2(MaxEdges);

    localparam logic [1:0] CMD_ADD   = 2'd0;
    localparam logic [1:0] CMD_SOLVE = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_UNREACH = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;

    localparam logic [1:0] MODE_HOPS = 2'd0;
    localparam logic [1:0] MODE_COST = 2'd1;
    localparam logic [1:0] MODE_TREE = 2'd2;
    localparam logic [1:0] MODE_PCT  = 2'd3;

    localparam logic [1:0] REG_MODE  = 2'd0;
    localparam logic [1:0] REG_COUNT = 2'd1;
    localparam logic [1:0] REG_START = 2'd2;
    localparam logic [1:0] REG_FINAL = 2'd3;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [7:0]  edge_from;
        logic [7:0]  edge_to;
        logic [15:0] edge_weight;
    } t_in_item;

    typedef struct packed {
        logic [31:0] result_value;
        logic [1:0]  status;
    } t_out_item;

    // one vertex table word: reached flag, done flag and label
    typedef struct packed {
        logic        reach;
        logic        done;
        logic [31:0] label;
    } t_vtx;
endpackage
`default_nettype wire

// File: src/graph_path_and_tree_solver_unit.sv
// Top level of the graph path and tree solver: edge store, vertex tables,
// scan sequencer and shared arithmetic. Depends on gpts_pkg and gpts_ram.
//
// channel | direction | handshake      | payload
// in      | input     | valid / stall  | t_in_item  (cmd, edge ends, weight)
// out     | output    | valid / stall  | t_out_item (result_value, status)
// cfg     | input     | valid / ready  | index, 32-bit data
//
// Add and clear go straight to the result register. A solve first
// initialises the vertex table, then runs rounds of a vertex scan and an
// edge walk, with label and update steps per relaxing edge (and a four-step
// division by 100 in percent mode); one round per reached vertex and a last
// empty scan; then the tree sum or the final label read, and the result is raised.
// Synchronous active-low reset clears control state and the edge count only;
// the vertex table is reinitialised by each solve. Output stall holds the result register; the
// block takes no new item until the result is gone.
`timescale 1ns / 1ps
`default_nettype none
module graph_path_and_tree_solver_unit
    import gpts_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_valid,
    output logic          o_stall,
    input  wire t_in_item i_item,
    output logic          o_valid,
    input  wire logic     i_stall,
    output t_out_item     o_item,
    input  wire logic     i_cfg_valid,
    output logic          o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [31:0] i_cfg_data
);
    localparam logic [3:0] S_IDLE = 4'd0, S_INIT = 4'd1, S_PICK = 4'd2,
        S_PICKW = 4'd3, S_EDGE = 4'd4, S_EDGEW = 4'd5, S_LBL = 4'd6,
        S_LBLW = 4'd7, S_MUL = 4'd8, S_DIV = 4'd9, S_UPD = 4'd10,
        S_SUM = 4'd11, S_SUMW = 4'd12, S_FIN = 4'd13, S_FINW = 4'd14,
        S_OUT = 4'd15;

    // ceil(2^30 / 100): exact quotient for every dividend below 100 * 2^16
    localparam logic [23:0] RecipHundred = 24'd10737419;

    logic [3:0] r_state;
    logic [1:0] r_mode;
    logic [8:0] r_count;
    logic [7:0] r_start, r_final;
    logic [EdgeW:0] r_etot;

    logic        r_ovalid;
    t_out_item   r_oitem;

    logic [VtxW:0]   r_vi;      // vertex scan counter
    logic [VtxW-1:0] r_u, r_nb;
    logic            r_found;
    logic [31:0]     r_best, r_ulab, r_cand;
    logic [EdgeW:0]  r_ei;
    logic [15:0]     r_w;
    logic [32:0]     r_sum;
    logic [48:0]     r_prod;
    logic [2:0]      r_dcnt;
    logic [6:0]      r_rem;
    logic [63:0]     r_quo;

    // edge RAMs
    logic            e_we;
    logic [EdgeW-1:0] e_wa, e_ra;
    logic [7:0]      e_from, e_to;
    logic [15:0]     e_wt;
    gpts_ram #(.Width(8),  .Depth(MaxEdges)) u_efrom (.i_clk, .i_we(e_we),
        .i_waddr(e_wa), .i_wdata(i_item.edge_from), .i_raddr(e_ra), .o_rdata(e_from));
    gpts_ram #(.Width(8),  .Depth(MaxEdges)) u_eto (.i_clk, .i_we(e_we),
        .i_waddr(e_wa), .i_wdata(i_item.edge_to), .i_raddr(e_ra), .o_rdata(e_to));
    gpts_ram #(.Width(16), .Depth(MaxEdges)) u_ewt (.i_clk, .i_we(e_we),
        .i_waddr(e_wa), .i_wdata(i_item.edge_weight), .i_raddr(e_ra), .o_rdata(e_wt));

    // vertex table RAM: reached and done flags beside each label
    logic            l_we;
    logic [VtxW-1:0] l_wa, l_ra;
    t_vtx            l_wd, l_rd;
    gpts_ram #(.Width($bits(t_vtx)), .Depth(MaxVertices)) u_lbl (.i_clk, .i_we(l_we),
        .i_waddr(l_wa), .i_wdata(l_wd), .i_raddr(l_ra), .o_rdata(l_rd));

    logic [8:0] n_eff;
    assign n_eff = (r_count > 9'(MaxVertices)) ? 9'(MaxVertices) : r_count;

    logic acc_in;
    assign acc_in   = i_valid && !o_stall;
    assign o_stall  = (r_state != S_IDLE) || r_ovalid;
    assign o_valid  = r_ovalid;
    assign o_item   = r_oitem;
    assign o_cfg_ready = (r_state == S_IDLE) && !r_ovalid;

    // edge end checks against the vertex range
    logic ein, ea_u, eb_u;
    logic [VtxW-1:0] e_nb;
    assign ein  = ({1'b0, e_from} < n_eff) && ({1'b0, e_to} < n_eff);
    assign ea_u = e_from == r_u;
    assign eb_u = e_to == r_u;
    assign e_nb = ea_u ? e_to : e_from;

    // solve runs only with start (and final, outside tree mode) in range
    logic solve_ok;
    assign solve_ok = {1'b0, r_start} < n_eff &&
                      (r_mode == MODE_TREE || {1'b0, r_final} < n_eff);

    // status of the item taken in idle; a solve starts as unreachable
    logic [1:0] idle_status;
    always_comb begin
        idle_status = ST_OK;
        if (i_item.cmd == CMD_ADD) begin
            idle_status = (r_etot == (EdgeW+1)'(MaxEdges)) ? ST_FULL : ST_OK;
        end else if (i_item.cmd == CMD_SOLVE) begin
            idle_status = ST_UNREACH;
        end
    end

    // one base-2^16 digit of the division by 100 per step
    logic [22:0] div_t;
    logic [46:0] div_p;
    logic [15:0] div_q;
    logic [22:0] div_back, div_left;
    logic [6:0]  div_r;
    assign div_t    = {r_rem, r_quo[63:48]};
    assign div_p    = {24'd0, div_t} * {23'd0, RecipHundred};
    assign div_q    = div_p[45:30];
    assign div_back = {7'd0, div_q} * 23'd100;
    assign div_left = div_t - div_back;
    assign div_r    = div_left[6:0];

    // percent of the final multiplier above one
    logic [31:0] pct_extra;
    logic [38:0] pct_scaled;
    assign pct_extra  = (l_rd.label >= 32'h10000) ? l_rd.label - 32'h10000 : 32'd0;
    assign pct_scaled = {7'd0, pct_extra} * 39'd100;

    always_comb begin
        e_we = acc_in && i_item.cmd == CMD_ADD && r_etot != (EdgeW+1)'(MaxEdges);
        e_wa = r_etot[EdgeW-1:0];
        e_ra = r_ei[EdgeW-1:0];
        l_we = 1'b0;
        l_wa = r_vi[VtxW-1:0];
        l_wd = '0;
        l_ra = r_vi[VtxW-1:0];
        unique case (r_state)
            S_INIT: begin
                l_we = 1'b1;
                l_wd = '{reach: r_vi[VtxW-1:0] == r_start, done: 1'b0,
                         label: (r_vi[VtxW-1:0] == r_start && r_mode == MODE_PCT) ?
                                32'h10000 : 32'd0};
            end
            S_EDGE: begin
                // mark the picked vertex done before its edges are walked
                if (r_ei == '0) begin
                    l_we = 1'b1;
                    l_wa = r_u;
                    l_wd = '{reach: 1'b1, done: 1'b1, label: r_best};
                end
            end
            S_LBL, S_LBLW: l_ra = r_nb;
            S_UPD: begin
                l_we = !l_rd.done && (!l_rd.reach || r_cand < l_rd.label);
                l_wa = r_nb;
                l_wd = '{reach: 1'b1, done: 1'b0, label: r_cand};
            end
            S_FIN:  l_ra = r_final;
            default: ;
        endcase
    end

    function automatic logic [31:0] sat(input logic [32:0] v);
        return v[32] ? 32'hFFFF_FFFF : v[31:0];
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_mode   <= 2'd0;
            r_count  <= 9'd256;
            r_start  <= 8'd0;
            r_final  <= 8'd0;
            r_etot   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (r_ovalid && !i_stall) r_ovalid <= 1'b0;
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    REG_MODE:  r_mode  <= i_cfg_data[1:0];
                    REG_COUNT: r_count <= i_cfg_data[8:0];
                    REG_START: r_start <= i_cfg_data[7:0];
                    REG_FINAL: r_final <= i_cfg_data[7:0];
                endcase
            end
            unique case (r_state)
                S_IDLE: if (acc_in) begin
                    r_oitem <= '{result_value: 32'd0, status: idle_status};
                    r_state <= (i_item.cmd == CMD_SOLVE && solve_ok) ? S_INIT : S_OUT;
                    r_vi    <= '0;
                    priority if (i_item.cmd == CMD_ADD) begin
                        if (e_we) r_etot <= r_etot + 1'b1;
                    end else if (i_item.cmd == CMD_CLEAR) begin
                        r_etot <= '0;
                    end
                end
                S_INIT: begin
                    // clear labels and flags, mark the root reached
                    if (r_vi + 1'b1 >= (VtxW+1)'(n_eff)) begin
                        r_state <= S_PICK; r_vi <= '0; r_found <= 1'b0;
                    end else r_vi <= r_vi + 1'b1;
                end
                S_PICK: begin
                    // read entry at r_vi; compared next cycle
                    r_state <= S_PICKW;
                end
                S_PICKW: begin
                    if (l_rd.reach && !l_rd.done && (!r_found || l_rd.label < r_best)) begin
                        r_found <= 1'b1; r_best <= l_rd.label; r_u <= r_vi[VtxW-1:0];
                    end
                    if (r_vi + 1'b1 >= (VtxW+1)'(n_eff)) begin
                        r_vi <= '0;
                        if (r_found || (l_rd.reach && !l_rd.done)) begin
                            r_state <= S_EDGE;
                            r_ei    <= '0;
                        end else begin
                            r_state <= (r_mode == MODE_TREE) ? S_SUM : S_FIN;
                            r_sum   <= '0;
                        end
                    end else begin
                        r_vi <= r_vi + 1'b1; r_state <= S_PICK;
                    end
                end
                S_EDGE: begin
                    if (r_ei == '0) r_ulab <= r_best;
                    if (r_ei >= r_etot) begin
                        r_state <= S_PICK; r_found <= 1'b0;
                    end else r_state <= S_EDGEW;
                end
                S_EDGEW: begin
                    r_ei <= r_ei + 1'b1;
                    if (ein && (ea_u || eb_u)) begin
                        r_nb <= e_nb; r_w <= e_wt; r_state <= S_LBL;
                    end else r_state <= S_EDGE;
                end
                S_LBL: begin
                    unique case (r_mode)
                        MODE_HOPS: r_cand <= sat({1'b0, r_ulab} + 33'd1);
                        MODE_COST: r_cand <= sat({1'b0, r_ulab} + {17'd0, r_w});
                        MODE_TREE: r_cand <= {16'd0, r_w};
                        MODE_PCT:  r_prod <= r_ulab * (17'd100 + {1'b0, r_w});
                    endcase
                    r_state <= (r_mode == MODE_PCT) ? S_MUL : S_LBLW;
                end
                S_LBLW:  r_state <= S_UPD;
                S_MUL: begin
                    // divide by 100 in four 16-bit digits
                    r_rem <= '0; r_quo <= {15'd0, r_prod}; r_dcnt <= 3'd4; r_state <= S_DIV;
                end
                S_DIV: begin
                    if (r_dcnt == 3'd0) begin
                        r_cand  <= (|r_quo[63:32]) ? 32'hFFFF_FFFF : r_quo[31:0];
                        r_state <= S_LBLW;
                    end else begin
                        r_rem  <= div_r;
                        r_quo  <= {r_quo[47:0], div_q};
                        r_dcnt <= r_dcnt - 1'b1;
                    end
                end
                S_UPD: r_state <= S_EDGE;
                S_SUM: r_state <= S_SUMW;
                S_SUMW: begin
                    if (!l_rd.reach) begin
                        r_state <= S_OUT;
                    end else begin
                        r_sum <= {1'b0, sat(r_sum + {1'b0, l_rd.label})};
                        if (r_vi + 1'b1 >= (VtxW+1)'(n_eff)) begin
                            r_oitem <= '{result_value: sat(r_sum + {1'b0, l_rd.label}),
                                         status: ST_OK};
                            r_state <= S_OUT;
                        end else begin
                            r_vi <= r_vi + 1'b1; r_state <= S_SUM;
                        end
                    end
                end
                S_FIN: r_state <= S_FINW;
                S_FINW: begin
                    r_state <= S_OUT;
                    if (l_rd.reach) begin
                        if (r_mode == MODE_PCT) begin
                            r_oitem <= '{result_value: {9'd0, pct_scaled[38:16]},
                                         status: ST_OK};
                        end else begin
                            r_oitem <= '{result_value: l_rd.label, status: ST_OK};
                        end
                    end
                end
                S_OUT: begin
                    r_ovalid <= 1'b1;
                    r_state  <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// File: src/gpts_ram.sv
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module gpts_ram #(
    parameter int Width = 8,
    parameter int Depth = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(Depth)-1:0] i_waddr,
    input  wire logic [Width-1:0]         i_wdata,
    input  wire logic [$clog2(Depth)-1:0] i_raddr,
    output logic      [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];
    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// File: src/gpts_checker.sv
// Port-level checks for the solver top level, bound to it below.
// Depends on gpts_pkg.
`timescale 1ns / 1ps
`default_nettype none
module gpts_checker
    import gpts_pkg::*;
(
    input wire logic      i_clk,
    input wire logic      i_rst_n,
    input wire logic      i_valid,
    input wire logic      o_stall,
    input wire logic      o_valid,
    input wire logic      i_stall,
    input wire t_out_item o_item,
    input wire logic      o_cfg_ready
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_item))
        else $error("result changed under stall");
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("second item accepted while busy");
    a_cfg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cfg_ready |-> !o_valid)
        else $error("config open while result pending");
    a_st: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_item.status == ST_UNREACH |-> o_item.result_value == 32'd0)
        else $error("unreachable with non-zero value");
endmodule

bind graph_path_and_tree_solver_unit gpts_checker u_chk (.*);
`default_nettype wire

// File: verif/graph_path_and_tree_solver_unit_tb.sv
// Regression bench for graph_path_and_tree_solver_unit: directed and random edge loads
// and solves in all four modes, checked against an in-bench path and tree solver.
// Depends on gpts_pkg and the solver RTL only.
`timescale 1ns / 1ps
`default_nettype none
module graph_path_and_tree_solver_unit_tb;
    import gpts_pkg::*;

    // The block answers the spare command code with zero and changes nothing.
    localparam logic [1:0] CMD_SPARE = 2'd3;
    localparam longint unsigned Q_ONE = 64'd65536;
    localparam int CycleLimit = 10_000_000;
    localparam int RandomItems = 1500;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    t_in_item    i_item = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    t_out_item   o_item;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = REG_MODE;
    logic [31:0] i_cfg_data = '0;

    graph_path_and_tree_solver_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_item      (i_item),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_item      (o_item),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Items waiting to be offered, and results predicted but not yet seen.
    t_in_item  pending_items[$];
    t_out_item expected_results[$];

    // Shadow copy of the edge store and of the registers.
    logic [7:0]  edge_a[MaxEdges];
    logic [7:0]  edge_b[MaxEdges];
    logic [15:0] edge_w[MaxEdges];
    int          edge_count = 0;
    logic [1:0]  cur_mode = MODE_HOPS;
    logic [8:0]  cur_count = 9'd256;
    logic [7:0]  cur_start = 8'd0;
    logic [7:0]  cur_final = 8'd0;

    int  cycle = 0;
    int  errors = 0;
    int  items_queued = 0;
    int  results_checked = 0;
    int  solves_run[4] = '{0, 0, 0, 0};
    int  full_hits = 0;
    int  unreach_hits = 0;
    bit  item_taken = 1'b0;
    int  hold_left = 0;
    bit  hold_done = 1'b0;

    function automatic logic [31:0] sat32(input longint unsigned v);
        return (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
    endfunction

    // Label that a neighbour gets across one edge, per mode.
    function automatic logic [31:0] cross_edge(input logic [31:0] lbl, input logic [15:0] w);
        case (cur_mode)
            MODE_HOPS: return sat32(longint'(lbl) + 1);
            MODE_COST: return sat32(longint'(lbl) + longint'(w));
            MODE_TREE: return {16'd0, w};
            default:   return sat32((longint'(lbl) * (100 + longint'(w))) / 100);
        endcase
    endfunction

    // Scan-based Dijkstra / Prim / BFS over the shadow edge store.
    function automatic t_out_item solve_graph();
        t_out_item        r;
        logic [31:0]      lbl[MaxVertices];
        bit               done[MaxVertices];
        bit               seen[MaxVertices];
        int               n;
        int               u;
        int               nb;
        bit               found;
        logic [31:0]      cand;
        longint unsigned  sum;
        longint unsigned  m;
        r.result_value = '0;
        r.status = ST_UNREACH;
        n = (cur_count > MaxVertices) ? MaxVertices : int'(cur_count);
        if (cur_start >= n) return r;
        if (cur_mode != MODE_TREE && cur_final >= n) return r;
        for (int v = 0; v < n; v++) begin
            lbl[v] = '0;
            done[v] = 1'b0;
            seen[v] = 1'b0;
        end
        lbl[cur_start] = (cur_mode == MODE_PCT) ? Q_ONE[31:0] : 32'd0;
        seen[cur_start] = 1'b1;
        forever begin
            found = 1'b0;
            u = 0;
            for (int v = 0; v < n; v++) begin
                if (seen[v] && !done[v] && (!found || lbl[v] < lbl[u])) begin
                    u = v;
                    found = 1'b1;
                end
            end
            if (!found) break;
            done[u] = 1'b1;
            for (int e = 0; e < edge_count; e++) begin
                if (edge_a[e] >= n || edge_b[e] >= n) continue;
                if (edge_a[e] == u) nb = edge_b[e];
                else if (edge_b[e] == u) nb = edge_a[e];
                else continue;
                if (done[nb]) continue;
                cand = cross_edge(lbl[u], edge_w[e]);
                if (!seen[nb] || cand < lbl[nb]) begin
                    lbl[nb] = cand;
                    seen[nb] = 1'b1;
                end
            end
        end
        if (cur_mode == MODE_TREE) begin
            sum = 0;
            for (int v = 0; v < n; v++) begin
                if (!seen[v]) return r;
                sum += lbl[v];
            end
            r.result_value = sat32(sum);
        end else begin
            if (!seen[cur_final]) return r;
            if (cur_mode == MODE_PCT) begin
                m = lbl[cur_final];
                m = (m >= Q_ONE) ? m - Q_ONE : 0;
                r.result_value = 32'((m * 100) >> 16);
            end else begin
                r.result_value = lbl[cur_final];
            end
        end
        r.status = ST_OK;
        return r;
    endfunction

    // Apply one accepted item to the shadow state and return its result.
    function automatic t_out_item apply_item(input t_in_item it);
        t_out_item r;
        r = '0;
        case (it.cmd)
            CMD_ADD: begin
                if (edge_count >= MaxEdges) begin
                    r.status = ST_FULL;
                    full_hits++;
                end else begin
                    edge_a[edge_count] = it.edge_from;
                    edge_b[edge_count] = it.edge_to;
                    edge_w[edge_count] = it.edge_weight;
                    edge_count++;
                end
            end
            CMD_SOLVE: begin
                r = solve_graph();
                solves_run[cur_mode]++;
                if (r.status == ST_UNREACH) unreach_hits++;
            end
            CMD_CLEAR: edge_count = 0;
            default: ;
        endcase
        return r;
    endfunction

    // Sample at the rising edge: input acceptance, result check, watchdog.
    always @(posedge i_clk) begin
        cycle++;
        if (cycle > CycleLimit) begin
            $display("graph_path_and_tree_solver_unit regression: fail");
            $finish;
        end else if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                expected_results.push_back(apply_item(i_item));
                item_taken = 1'b1;
            end
            if (o_valid && !i_stall) begin
                if (expected_results.size() == 0) begin
                    $error("result with nothing expected: value %0d status %0d",
                           o_item.result_value, o_item.status);
                    errors++;
                end else begin
                    if (o_item.result_value !== expected_results[0].result_value) begin
                        $error("result_value expected %0d actual %0d",
                               expected_results[0].result_value, o_item.result_value);
                        errors++;
                    end
                    if (o_item.status !== expected_results[0].status) begin
                        $error("status expected %0d actual %0d",
                               expected_results[0].status, o_item.status);
                        errors++;
                    end
                    void'(expected_results.pop_front());
                    results_checked++;
                end
            end
        end
    end

    // Idle gaps everywhere except one calm window in the middle of the run.
    function automatic bit idle_now();
        return !(cycle >= 30000 && cycle < 60000) && ($urandom_range(0, 99) < 7);
    endfunction

    // Item driver: hold a stalled item, otherwise offer the next one or idle.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (i_valid && !item_taken) begin
            i_valid <= 1'b1;
        end else if (pending_items.size() > 0 && !idle_now()) begin
            i_item  <= pending_items.pop_front();
            i_valid <= 1'b1;
        end else begin
            i_valid <= 1'b0;
        end
        item_taken = 1'b0;
    end

    // Result sink: random stalls, plus one long hold-off so the block backs up.
    always @(negedge i_clk) begin
        if (!hold_done && cycle >= 2000 && pending_items.size() > 2) begin
            hold_left = 600;
            hold_done = 1'b1;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else begin
            i_stall <= idle_now();
        end
    end

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            REG_MODE:  cur_mode  = data[1:0];
            REG_COUNT: cur_count = data[8:0];
            REG_START: cur_start = data[7:0];
            default:   cur_final = data[7:0];
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_regs(input logic [1:0] md, input int cnt, input int st, input int fin);
        write_reg(REG_MODE, {30'd0, md});
        write_reg(REG_COUNT, cnt);
        write_reg(REG_START, st);
        write_reg(REG_FINAL, fin);
    endtask

    task automatic queue_item(input logic [1:0] cmd, input int a, input int b, input int w);
        t_in_item it;
        it.cmd = cmd;
        it.edge_from = a[7:0];
        it.edge_to = b[7:0];
        it.edge_weight = w[15:0];
        pending_items.push_back(it);
        items_queued++;
    endtask

    // Wait until every queued item is taken and its result checked, then pause.
    task automatic drain();
        while (pending_items.size() > 0 || i_valid || expected_results.size() > 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    // Weights: half full range to reach the top bits, half small for sane paths.
    function automatic int pick_weight();
        return ($urandom_range(0, 1) == 1) ? $urandom_range(0, 65535) : $urandom_range(0, 40);
    endfunction

    // Vertex picked mostly inside the live range, sometimes anywhere.
    function automatic int pick_vertex(input int n);
        if (n > 0 && $urandom_range(0, 99) < 90)
            return $urandom_range(0, ((n > MaxVertices) ? MaxVertices : n) - 1);
        return $urandom_range(0, 255);
    endfunction

    task automatic random_phase();
        int n;
        int len;
        int roll;
        n = ($urandom_range(0, 9) < 9) ? $urandom_range(1, 12) : $urandom_range(0, 511);
        set_regs(2'($urandom_range(0, 3)), n, pick_vertex(n), pick_vertex(n));
        queue_item(CMD_CLEAR, $urandom_range(0, 255), $urandom_range(0, 255), pick_weight());
        len = $urandom_range(8, 28);
        for (int k = 0; k < len; k++) begin
            roll = $urandom_range(0, 99);
            if (roll < 80)
                queue_item(CMD_ADD, pick_vertex(n), pick_vertex(n), pick_weight());
            else if (roll < 95)
                queue_item(CMD_SOLVE, $urandom_range(0, 255), $urandom_range(0, 255),
                           $urandom_range(0, 65535));
            else if (roll < 97)
                queue_item(CMD_CLEAR, 0, 0, 0);
            else
                queue_item(CMD_SPARE, $urandom_range(0, 255), $urandom_range(0, 255),
                           $urandom_range(0, 65535));
        end
        queue_item(CMD_SOLVE, 0, 0, 0);
        drain();
    endtask

    // Fill the edge store to the top, overflow it, and solve in every mode.
    task automatic fill_phase();
        set_regs(MODE_COST, 4, 0, 3);
        queue_item(CMD_CLEAR, 0, 0, 0);
        for (int k = 0; k < MaxEdges + 3; k++)
            queue_item(CMD_ADD, $urandom_range(0, 3), $urandom_range(0, 3), pick_weight());
        drain();
        for (int md = 0; md < 4; md++) begin
            write_reg(REG_MODE, md);
            queue_item(CMD_SOLVE, 0, 0, 0);
            drain();
        end
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: empty store, start equals final.
        queue_item(CMD_SOLVE, 0, 0, 0);
        queue_item(CMD_SPARE, 255, 255, 65535);
        drain();

        // Small line graph with a self loop and out-of-range ends.
        set_regs(MODE_HOPS, 3, 0, 2);
        queue_item(CMD_CLEAR, 0, 0, 0);
        queue_item(CMD_ADD, 0, 1, 0);
        queue_item(CMD_ADD, 1, 2, 65535);
        queue_item(CMD_ADD, 2, 2, 7);
        queue_item(CMD_ADD, 255, 0, 1);
        queue_item(CMD_ADD, 0, 255, 3);
        queue_item(CMD_SOLVE, 0, 0, 0);
        drain();
        for (int md = 1; md < 4; md++) begin
            write_reg(REG_MODE, md);
            queue_item(CMD_SOLVE, 0, 0, 0);
            drain();
        end

        // Disconnected tree, unreached final, bad final, bad start, no vertices.
        set_regs(MODE_TREE, 4, 0, 3);
        queue_item(CMD_SOLVE, 0, 0, 0);
        drain();
        write_reg(REG_MODE, MODE_COST);
        queue_item(CMD_SOLVE, 0, 0, 0);
        drain();
        write_reg(REG_FINAL, 200);
        queue_item(CMD_SOLVE, 0, 0, 0);
        drain();
        set_regs(MODE_PCT, 4, 9, 1);
        queue_item(CMD_SOLVE, 0, 0, 0);
        drain();
        set_regs(MODE_HOPS, 0, 0, 0);
        queue_item(CMD_SOLVE, 0, 0, 0);
        drain();
        // Oversized count acts as the full vertex range.
        set_regs(MODE_HOPS, 511, 255, 0);
        queue_item(CMD_ADD, 255, 1, 2);
        queue_item(CMD_SOLVE, 0, 0, 0);
        drain();

        items_queued = 0;
        while (items_queued < RandomItems) begin
            if (items_queued > 300 && full_hits == 0)
                fill_phase();
            else
                random_phase();
        end

        $display("checked %0d results: solves hops/cost/tree/pct %0d/%0d/%0d/%0d",
                 results_checked, solves_run[0], solves_run[1], solves_run[2], solves_run[3]);
        $display("unreachable answers %0d, store-full answers %0d", unreach_hits, full_hits);
        if (errors == 0) begin
            $display("graph_path_and_tree_solver_unit regression: pass");
        end else begin
            $display("graph_path_and_tree_solver_unit regression: fail");
        end
        $finish;
    end
endmodule
`default_nettype wire
